@@ sv/dtrd_pkg.sv @@
package dtrd_pkg;

    // number formats
    localparam int VALUE_W         = 32;
    localparam int VALUE_FRAC_BITS = 16;
    localparam int SCALE_W         = 24;
    localparam int SCALE_FRAC_BITS = 16;
    localparam int THRESH_W        = 17;
    localparam int CLASS_W         = 8;
    localparam int PIXEL_W         = 16;
    localparam int SCORE_W         = 17;

    // row layout
    localparam int BOX_VALUES    = 4;
    localparam int HEADER_VALUES = 5;
    localparam int POS_W         = 9;

    // product of a value and a zero-extended scale
    localparam int PROD_W = VALUE_W + SCALE_W + 1;
    // corner / size arithmetic width
    localparam int EDGE_W = VALUE_W + 2;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_NUM_CLASSES    = 3'd0,
        REG_OBJ_THRESHOLD  = 3'd1,
        REG_CONF_THRESHOLD = 3'd2,
        REG_H_SCALE        = 3'd3,
        REG_V_SCALE        = 3'd4
    } cfg_reg_t;

    // reset values of the registers
    localparam logic [CLASS_W-1:0]  NUM_CLASSES_RST    = 8'd80;
    localparam logic [THRESH_W-1:0] OBJ_THRESHOLD_RST  = 17'd32768;
    localparam logic [THRESH_W-1:0] CONF_THRESHOLD_RST = 17'd16384;
    localparam logic [SCALE_W-1:0]  SCALE_RST          = 24'd65536;

    localparam logic signed [VALUE_W-1:0] SCORE_ONE = VALUE_W'(1 << VALUE_FRAC_BITS);

    // product / 2^16 truncated toward zero, saturated to 32 bits signed
    function automatic logic signed [VALUE_W-1:0] scale_trunc(
        input logic signed [PROD_W-1:0] p
    );
        logic signed [PROD_W-1:0]                 biased;
        logic        [PROD_W-SCALE_FRAC_BITS-1:0] q;
        logic        [VALUE_W-1:0]                res;
        biased = p + (p[PROD_W-1] ? PROD_W'((1 << SCALE_FRAC_BITS) - 1) : PROD_W'(0));
        q      = biased[PROD_W-1:SCALE_FRAC_BITS];
        if (q[PROD_W-SCALE_FRAC_BITS-1:VALUE_W-1] == '0 ||
            q[PROD_W-SCALE_FRAC_BITS-1:VALUE_W-1] == '1)
        begin
            res = q[VALUE_W-1:0];
        end
        else if (q[PROD_W-SCALE_FRAC_BITS-1])
        begin
            res = {1'b1, {(VALUE_W-1){1'b0}}};
        end
        else
        begin
            res = {1'b0, {(VALUE_W-1){1'b1}}};
        end
        return $signed(res);
    endfunction

    // v / 2^frac truncated toward zero, saturated to 16 bits signed
    function automatic logic signed [PIXEL_W-1:0] to_pixels(
        input logic signed [EDGE_W-1:0] v,
        input int                       frac
    );
        logic signed [EDGE_W-1:0]  bias;
        logic signed [EDGE_W-1:0]  q;
        logic        [PIXEL_W-1:0] res;
        bias = v[EDGE_W-1] ? ((EDGE_W'(1) <<< frac) - EDGE_W'(1)) : EDGE_W'(0);
        q    = (v + bias) >>> frac;
        if (q[EDGE_W-1:PIXEL_W-1] == '0 || q[EDGE_W-1:PIXEL_W-1] == '1)
        begin
            res = q[PIXEL_W-1:0];
        end
        else if (q[EDGE_W-1])
        begin
            res = {1'b1, {(PIXEL_W-1){1'b0}}};
        end
        else
        begin
            res = {1'b0, {(PIXEL_W-1){1'b1}}};
        end
        return $signed(res);
    endfunction

endpackage

@@ sv/detection_row_decoder.sv @@
// Detection row decoder: one tensor element per item, one box per qualifying row.
// Throughput: one item per cycle, sustained, while results are taken.
// After the last item of its row is accepted, a result passes through the input
// register, the product register and the output register before it is presented.
// Reset (rst_n low, asynchronous) empties the pipe, restarts the row at its first
// element and loads a class count of 80, thresholds 0.5 / 0.25, scales 1.0.
module detection_row_decoder
    import dtrd_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,

    // configuration write port
    input  logic                       cfg_write_enable,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,

    // tensor elements
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [VALUE_W-1:0]  tensor_value,

    // decoded boxes
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [PIXEL_W-1:0]  box_left,
    output logic signed [PIXEL_W-1:0]  box_top,
    output logic signed [PIXEL_W-1:0]  box_width,
    output logic signed [PIXEL_W-1:0]  box_height,
    output logic [CLASS_W-1:0]         class_index,
    output logic [SCORE_W-1:0]         class_score
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CLASS_W-1:0]  num_classes_reg;
    logic [THRESH_W-1:0] obj_thresh_reg;
    logic [THRESH_W-1:0] conf_thresh_reg;
    logic [SCALE_W-1:0]  h_scale_reg;
    logic [SCALE_W-1:0]  v_scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_classes_reg <= NUM_CLASSES_RST;
            obj_thresh_reg  <= OBJ_THRESHOLD_RST;
            conf_thresh_reg <= CONF_THRESHOLD_RST;
            h_scale_reg     <= SCALE_RST;
            v_scale_reg     <= SCALE_RST;
        end
        else if (cfg_write_enable)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_NUM_CLASSES:    num_classes_reg <= cfg_data[CLASS_W-1:0];
                REG_OBJ_THRESHOLD:  obj_thresh_reg  <= cfg_data[THRESH_W-1:0];
                REG_CONF_THRESHOLD: conf_thresh_reg <= cfg_data[THRESH_W-1:0];
                REG_H_SCALE:        h_scale_reg     <= cfg_data;
                REG_V_SCALE:        v_scale_reg     <= cfg_data;
                default:            ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control. Each stage moves on when the one after it has room;
    // stage 2 only needs the output register when it carries a result.
    // ------------------------------------------------------------------
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic out_valid_reg, out_valid_next;

    logic s2_last_reg;
    logic row_pass_reg;
    logic class_found_reg;

    logic out_free;
    logic s2_emit;
    logic s2_adv;
    logic s1_adv;
    logic in_fire;

    always_comb
    begin
        out_free = !out_valid_reg || out_ready;
        s2_emit  = s2_last_reg && row_pass_reg && class_found_reg;
        s2_adv   = s2_valid_reg && (!s2_emit || out_free);
        s1_adv   = s1_valid_reg && (!s2_valid_reg || s2_adv);
        in_ready = !s1_valid_reg || s1_adv;
        in_fire  = in_valid && in_ready;

        s1_valid_next  = in_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        s2_valid_next  = s1_adv  ? 1'b1 : (s2_adv ? 1'b0 : s2_valid_reg);
        out_valid_next = (s2_adv && s2_emit) ? 1'b1 :
                         (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // ------------------------------------------------------------------
    // Row position, tracked at the input so each item carries its place.
    // A class count of zero counts as one class.
    // ------------------------------------------------------------------
    logic [POS_W-1:0] position_reg, position_next;
    logic [POS_W-1:0] last_pos;
    logic             is_last;

    always_comb
    begin
        last_pos = POS_W'(HEADER_VALUES - 1) +
                   ((num_classes_reg == '0) ? POS_W'(1) : POS_W'(num_classes_reg));
        is_last  = (position_reg >= last_pos);
        position_next = position_reg;
        if (in_fire)
        begin
            position_next = is_last ? '0 : position_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
        end
        else
        begin
            position_reg <= position_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input register
    // ------------------------------------------------------------------
    logic signed [VALUE_W-1:0] s1_value_reg;
    logic [POS_W-1:0]          s1_pos_reg;
    logic                      s1_last_reg;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_value_reg <= tensor_value;
            s1_pos_reg   <= position_reg;
            s1_last_reg  <= is_last;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 -> 2: box scaling multiply, objectness test, class search.
    // Centre x and width use the horizontal scale, centre y and height the
    // vertical one.
    // ------------------------------------------------------------------
    logic [SCALE_W-1:0]           scale_sel;
    logic signed [PROD_W-1:0]     product;
    logic signed [VALUE_W:0]      value_ext;
    logic signed [VALUE_W:0]      obj_thresh_ext;
    logic signed [VALUE_W:0]      conf_thresh_ext;
    logic signed [VALUE_W-1:0]    best_score_reg;
    logic [CLASS_W-1:0]           best_class_reg;
    logic                         beats_best;

    always_comb
    begin
        scale_sel       = s1_pos_reg[0] ? v_scale_reg : h_scale_reg;
        product         = s1_value_reg * $signed({1'b0, scale_sel});
        value_ext       = {s1_value_reg[VALUE_W-1], s1_value_reg};
        obj_thresh_ext  = $signed({{(VALUE_W+1-THRESH_W){1'b0}}, obj_thresh_reg});
        conf_thresh_ext = $signed({{(VALUE_W+1-THRESH_W){1'b0}}, conf_thresh_reg});
        // strictly greater: an equal later score keeps the earlier class
        beats_best      = (value_ext > conf_thresh_ext) && (s1_value_reg > best_score_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_pass_reg    <= 1'b0;
            best_class_reg  <= '0;
            best_score_reg  <= '0;
            class_found_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            if (s1_pos_reg == POS_W'(BOX_VALUES))
            begin
                // objectness element: decide the row, restart the search
                row_pass_reg    <= (value_ext >= obj_thresh_ext);
                best_class_reg  <= '0;
                best_score_reg  <= '0;
                class_found_reg <= 1'b0;
            end
            else if (s1_pos_reg >= POS_W'(HEADER_VALUES) && beats_best)
            begin
                best_class_reg  <= CLASS_W'(s1_pos_reg - POS_W'(HEADER_VALUES));
                best_score_reg  <= s1_value_reg;
                class_found_reg <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: product register
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] s2_product_reg;
    logic [POS_W-1:0]         s2_pos_reg;

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_product_reg <= product;
            s2_pos_reg     <= s1_pos_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_last_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            s2_last_reg <= s1_last_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2 exit: store scaled box values; at row end build the result.
    // box_reg holds centre x, centre y, width, height in that order.
    // ------------------------------------------------------------------
    logic signed [VALUE_W-1:0] box_reg [BOX_VALUES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BOX_VALUES; i++)
            begin
                box_reg[i] <= '0;
            end
        end
        else if (s2_adv && s2_pos_reg < POS_W'(BOX_VALUES))
        begin
            box_reg[s2_pos_reg[1:0]] <= scale_trunc(s2_product_reg);
        end
    end

    // corners as (2*c - size) / 2^(frac+1), sizes as size / 2^frac
    logic signed [EDGE_W-1:0]  left_edge;
    logic signed [EDGE_W-1:0]  top_edge;
    logic signed [EDGE_W-1:0]  width_ext;
    logic signed [EDGE_W-1:0]  height_ext;
    logic [SCORE_W-1:0]        score_sat;

    always_comb
    begin
        width_ext  = EDGE_W'(box_reg[2]);
        height_ext = EDGE_W'(box_reg[3]);
        left_edge  = (EDGE_W'(box_reg[0]) <<< 1) - width_ext;
        top_edge   = (EDGE_W'(box_reg[1]) <<< 1) - height_ext;
        // score is above a non-negative threshold, so only the top clip matters
        score_sat  = (best_score_reg > SCORE_ONE) ? SCORE_ONE[SCORE_W-1:0]
                                                  : best_score_reg[SCORE_W-1:0];
    end

    logic signed [PIXEL_W-1:0] box_left_reg;
    logic signed [PIXEL_W-1:0] box_top_reg;
    logic signed [PIXEL_W-1:0] box_width_reg;
    logic signed [PIXEL_W-1:0] box_height_reg;
    logic [CLASS_W-1:0]        class_index_reg;
    logic [SCORE_W-1:0]        class_score_reg;

    always_ff @(posedge clk)
    begin
        if (s2_adv && s2_emit)
        begin
            box_left_reg    <= to_pixels(left_edge,  VALUE_FRAC_BITS + 1);
            box_top_reg     <= to_pixels(top_edge,   VALUE_FRAC_BITS + 1);
            box_width_reg   <= to_pixels(width_ext,  VALUE_FRAC_BITS);
            box_height_reg  <= to_pixels(height_ext, VALUE_FRAC_BITS);
            class_index_reg <= best_class_reg;
            class_score_reg <= score_sat;
        end
    end

    assign box_left    = box_left_reg;
    assign box_top     = box_top_reg;
    assign box_width   = box_width_reg;
    assign box_height  = box_height_reg;
    assign class_index = class_index_reg;
    assign class_score = class_score_reg;

endmodule

@@ bench/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dtrd_pkg::*;

    // watchdog: cycles with no item moving on either channel
    localparam int WATCHDOG_LIMIT = 4000;
    // long receiver hold-off used to fill the pipe
    localparam int HOLD_CYCLES    = 400;
    // cycles allowed for an item with no result to leave the pipe
    localparam int DRAIN_CYCLES   = 6;

    // element positions within a row
    localparam int POS_CENTER_X = 0;
    localparam int POS_CENTER_Y = 1;
    localparam int POS_WIDTH    = 2;
    localparam int POS_HEIGHT   = 3;

    localparam longint INT32_MAX = 64'sd2147483647;
    localparam longint INT32_MIN = -64'sd2147483648;

    typedef struct {
        logic signed [PIXEL_W-1:0] left;
        logic signed [PIXEL_W-1:0] top;
        logic signed [PIXEL_W-1:0] width;
        logic signed [PIXEL_W-1:0] height;
        logic [CLASS_W-1:0]        class_idx;
        logic [SCORE_W-1:0]        score;
    } box_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_write_enable = 1'b0;
    logic [CFG_INDEX_W-1:0]    cfg_index = REG_NUM_CLASSES;
    logic [CFG_DATA_W-1:0]     cfg_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic signed [VALUE_W-1:0] tensor_value = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic signed [PIXEL_W-1:0] box_left;
    logic signed [PIXEL_W-1:0] box_top;
    logic signed [PIXEL_W-1:0] box_width;
    logic signed [PIXEL_W-1:0] box_height;
    logic [CLASS_W-1:0]        class_index;
    logic [SCORE_W-1:0]        class_score;

    detection_row_decoder DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .tensor_value     (tensor_value),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .box_left         (box_left),
        .box_top          (box_top),
        .box_width        (box_width),
        .box_height       (box_height),
        .class_index      (class_index),
        .class_score      (class_score)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Decoder prediction: own copy of the registers and the row state
    // ------------------------------------------------------------------
    logic [CLASS_W-1:0]        cfg_classes   = NUM_CLASSES_RST;
    logic [THRESH_W-1:0]       cfg_obj_thr   = OBJ_THRESHOLD_RST;
    logic [THRESH_W-1:0]       cfg_conf_thr  = CONF_THRESHOLD_RST;
    logic [SCALE_W-1:0]        cfg_h_scale   = SCALE_RST;
    logic [SCALE_W-1:0]        cfg_v_scale   = SCALE_RST;

    int                        row_pos       = 0;
    logic signed [VALUE_W-1:0] row_cx        = '0;
    logic signed [VALUE_W-1:0] row_cy        = '0;
    logic signed [VALUE_W-1:0] row_w         = '0;
    logic signed [VALUE_W-1:0] row_h         = '0;
    logic                      row_obj_ok    = 1'b0;
    logic [CLASS_W-1:0]        row_best_idx  = '0;
    logic signed [VALUE_W-1:0] row_best_val  = '0;
    logic                      row_has_class = 1'b0;

    box_t pending_boxes[$];

    int mismatch_count = 0;
    int elements_sent  = 0;
    int idle_pct       = 27;
    bit hold_request   = 1'b0;
    int hold_left      = 0;
    int stall_cycles   = 0;

    // value * scale / 2^16, truncated toward zero, clamped to 32 bits
    function automatic logic signed [VALUE_W-1:0] scale_q16(
        input longint           val,
        input logic [SCALE_W-1:0] factor
    );
        longint prod;
        longint f;
        f    = factor;
        prod = (val * f) / (longint'(1) << SCALE_FRAC_BITS);
        if (prod > INT32_MAX)
        begin
            prod = INT32_MAX;
        end
        else if (prod < INT32_MIN)
        begin
            prod = INT32_MIN;
        end
        return prod[VALUE_W-1:0];
    endfunction

    // fixed point to whole pixels, truncated toward zero, clamped to 16 bits
    function automatic logic signed [PIXEL_W-1:0] whole_pixels(
        input longint val,
        input int     shift
    );
        longint q;
        q = val / (longint'(1) << shift);
        if (q > 32767)
        begin
            q = 32767;
        end
        else if (q < -32768)
        begin
            q = -32768;
        end
        return q[PIXEL_W-1:0];
    endfunction

    // advance the row state by one element; queue a box at a qualifying row end
    task automatic decode_element(input logic signed [VALUE_W-1:0] v);
        longint val;
        longint row_last;
        longint cx, cy, w, h, score;
        box_t   b;
        val      = v;
        row_last = HEADER_VALUES - 1 + ((cfg_classes == 0) ? 1 : cfg_classes);
        if (row_pos == POS_CENTER_X)
        begin
            row_cx = scale_q16(val, cfg_h_scale);
        end
        else if (row_pos == POS_CENTER_Y)
        begin
            row_cy = scale_q16(val, cfg_v_scale);
        end
        else if (row_pos == POS_WIDTH)
        begin
            row_w = scale_q16(val, cfg_h_scale);
        end
        else if (row_pos == POS_HEIGHT)
        begin
            row_h = scale_q16(val, cfg_v_scale);
        end
        else if (row_pos == BOX_VALUES)
        begin
            // objectness: signed compare, inclusive; restarts the class search
            row_obj_ok    = (val >= longint'(cfg_obj_thr));
            row_best_idx  = '0;
            row_best_val  = '0;
            row_has_class = 1'b0;
        end
        else if (val > longint'(cfg_conf_thr) && val > longint'(row_best_val))
        begin
            // strictly greater: a tie keeps the earlier class
            row_best_idx  = CLASS_W'(row_pos - HEADER_VALUES);
            row_best_val  = v;
            row_has_class = 1'b1;
        end

        if (row_pos >= row_last)
        begin
            if (row_pos >= HEADER_VALUES && row_obj_ok && row_has_class)
            begin
                cx    = row_cx;
                cy    = row_cy;
                w     = row_w;
                h     = row_h;
                score = row_best_val;
                if (score > (longint'(1) << VALUE_FRAC_BITS))
                begin
                    score = longint'(1) << VALUE_FRAC_BITS;
                end
                b.left      = whole_pixels(2 * cx - w, VALUE_FRAC_BITS + 1);
                b.top       = whole_pixels(2 * cy - h, VALUE_FRAC_BITS + 1);
                b.width     = whole_pixels(w, VALUE_FRAC_BITS);
                b.height    = whole_pixels(h, VALUE_FRAC_BITS);
                b.class_idx = row_best_idx;
                b.score     = score[SCORE_W-1:0];
                pending_boxes.insert(pending_boxes.size(), b);
            end
            row_pos = 0;
        end
        else
        begin
            row_pos = row_pos + 1;
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_left == 0 && hold_request)
        begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    task automatic compare_field(input string field, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatch_count++;
        end
    endtask

    // result checker: every accepted box against the oldest prediction
    always @(posedge clk)
    begin
        box_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_boxes.size() == 0)
            begin
                $error("box_left: expected no item, got %0d", box_left);
                mismatch_count++;
            end
            else
            begin
                want = pending_boxes.pop_front();
                compare_field("box_left",    want.left,      box_left);
                compare_field("box_top",     want.top,       box_top);
                compare_field("box_width",   want.width,     box_width);
                compare_field("box_height",  want.height,    box_height);
                compare_field("class_index", want.class_idx, class_index);
                compare_field("class_score", want.score,     class_score);
            end
        end
    end

    // watchdog: ends the run if nothing moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // one tensor element; valid stays up between back-to-back items
    task automatic send_element(input logic signed [VALUE_W-1:0] v);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        tensor_value <= v;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        decode_element(v);
        elements_sent++;
    endtask

    task automatic send_header(
        input logic signed [VALUE_W-1:0] cx,
        input logic signed [VALUE_W-1:0] cy,
        input logic signed [VALUE_W-1:0] w,
        input logic signed [VALUE_W-1:0] h,
        input logic signed [VALUE_W-1:0] obj
    );
        send_element(cx);
        send_element(cy);
        send_element(w);
        send_element(h);
        send_element(obj);
    endtask

    // stop offering, wait for every box, then let stragglers leave the pipe
    task automatic drain_pipeline();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_boxes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // only called with the block idle
    task automatic write_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write_enable <= 1'b1;
        cfg_index        <= idx;
        cfg_data         <= data;
        case (idx)
            REG_NUM_CLASSES:    cfg_classes  = data[CLASS_W-1:0];
            REG_OBJ_THRESHOLD:  cfg_obj_thr  = data[THRESH_W-1:0];
            REG_CONF_THRESHOLD: cfg_conf_thr = data[THRESH_W-1:0];
            REG_H_SCALE:        cfg_h_scale  = data;
            REG_V_SCALE:        cfg_v_scale  = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_write_enable <= 1'b0;
    endtask

    function automatic logic signed [VALUE_W-1:0] px(input int n);
        return VALUE_W'(n) <<< VALUE_FRAC_BITS;
    endfunction

    function automatic logic signed [VALUE_W-1:0] random_box_value();
        case ($urandom_range(4))
            0: return $urandom;
            1: return $urandom_range(0, 65536000);
            2: return VALUE_W'(-longint'($urandom_range(0, 65536000)));
            3: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    // near the threshold on either side, fully random, or up to 65536 above it
    function automatic logic signed [VALUE_W-1:0] random_objectness();
        longint thr;
        thr = cfg_obj_thr;
        case ($urandom_range(5))
            0: return VALUE_W'(thr + $urandom_range(0, 2));
            1: return VALUE_W'(thr - 1 - $urandom_range(0, 2));
            2: return $urandom;
            default: return VALUE_W'(thr + $urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic signed [VALUE_W-1:0] random_score();
        longint thr;
        thr = cfg_conf_thr;
        case ($urandom_range(5))
            0: return VALUE_W'(thr - $urandom_range(0, 2));
            1: return $urandom;
            2: return VALUE_W'(thr + $urandom_range(0, 3));
            3: return $urandom_range(0, 131071);
            default: return VALUE_W'(thr + 1 + $urandom_range(0, 70000));
        endcase
    endfunction

    // full-length row; most are well formed, some pure noise
    task automatic send_random_row(input int n_classes);
        bit                        noise;
        logic signed [VALUE_W-1:0] v;
        noise = ($urandom_range(99) < 15);
        for (int i = 0; i < n_classes + HEADER_VALUES; i++)
        begin
            if (noise)
            begin
                v = $urandom;
            end
            else if (i < BOX_VALUES)
            begin
                v = random_box_value();
            end
            else if (i == BOX_VALUES)
            begin
                v = random_objectness();
            end
            else
            begin
                v = random_score();
            end
            send_element(v);
        end
    endtask

    function automatic logic [THRESH_W-1:0] pick_threshold();
        case ($urandom_range(4))
            0: return '0;
            1: return THRESH_W'(65536);
            default: return THRESH_W'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic [SCALE_W-1:0] pick_scale();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            2: return SCALE_RST;
            default: return SCALE_W'($urandom_range(0, 4 << SCALE_FRAC_BITS));
        endcase
    endfunction

    // one setting of all registers, then random rows up to the item budget
    task automatic random_phase(input int n_items, input logic [CLASS_W-1:0] classes);
        int target;
        int n_classes;
        target    = elements_sent + n_items;
        n_classes = (classes == 0) ? 1 : classes;
        write_register(REG_NUM_CLASSES, CFG_DATA_W'(classes));
        write_register(REG_OBJ_THRESHOLD, CFG_DATA_W'(pick_threshold()));
        write_register(REG_CONF_THRESHOLD, CFG_DATA_W'(pick_threshold()));
        write_register(REG_H_SCALE, pick_scale());
        write_register(REG_V_SCALE, pick_scale());
        while (elements_sent < target)
        begin
            send_random_row(n_classes);
        end
        drain_pipeline();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // objectness exactly at and just below its threshold; class count zero acts as one
    task automatic test_threshold_edges();
        write_register(REG_NUM_CLASSES, CFG_DATA_W'(0));
        send_header(px(100), px(50), px(41), px(-7), 32'sd32768);
        send_element(32'sd16385);
        send_header(px(-3), 32'sd12345, px(5), px(5), 32'sd32767);
        send_element(32'sh7FFF_FFFF);
        drain_pipeline();
    endtask

    // class count shrunk mid row: the next item closes the row; a tie and a
    // score equal to the threshold both leave the first class in place
    task automatic test_class_count_mid_row();
        write_register(REG_NUM_CLASSES, CFG_DATA_W'(3));
        send_header(px(320), px(240), px(64), px(48), 32'sd65536);
        send_element(32'sd40000);
        send_element(32'sd40000);
        drain_pipeline();
        write_register(REG_NUM_CLASSES, CFG_DATA_W'(1));
        send_element(32'sd16384);
        drain_pipeline();
    endtask

    // largest scales on extreme values: the scaling, the corners and the score all saturate
    task automatic test_saturation();
        write_register(REG_H_SCALE, '1);
        write_register(REG_V_SCALE, '1);
        send_header(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                    32'sh7FFF_FFFF);
        send_element(32'sh7FFF_FFFF);
        drain_pipeline();
    endtask

    // receiver holds off while rows keep coming, so the input stalls
    task automatic test_back_pressure();
        write_register(REG_NUM_CLASSES, CFG_DATA_W'(1));
        write_register(REG_OBJ_THRESHOLD, CFG_DATA_W'(0));
        write_register(REG_CONF_THRESHOLD, CFG_DATA_W'(0));
        write_register(REG_H_SCALE, SCALE_RST);
        write_register(REG_V_SCALE, SCALE_RST);
        hold_request = 1'b1;
        repeat (34) send_random_row(1);
        drain_pipeline();
    endtask

    task automatic test_random_rows();
        random_phase(300, CLASS_W'($urandom_range(1, 4)));
        random_phase(300, CLASS_W'($urandom_range(5, 12)));
        random_phase(300, 8'd255);
        random_phase(300, CLASS_W'($urandom_range(0, 1)));
    endtask

    // a long run with neither side idling
    task automatic test_unbroken_stream();
        idle_pct = 0;
        random_phase(300, CLASS_W'($urandom_range(2, 40)));
        idle_pct = 27;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_threshold_edges();
        test_class_count_mid_row();
        test_saturation();
        test_back_pressure();
        test_random_rows();
        test_unbroken_stream();

        drain_pipeline();
        if (mismatch_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
